### src/dhbd_pkg.sv
// Shared constants, types and register codes for the detection head box decoder
`default_nettype none

package dhbd_pkg;

    localparam int CLASS_COUNT_DEF = 80;
    localparam int NUM_COEFFS_DEF  = 32;

    localparam int VALUE_W  = 32;
    localparam int CLASS_W  = 8;
    localparam int CORNER_W = 29;
    localparam int SUM_W    = 34;
    localparam int PROD_W   = 59;

    localparam int THRESH_W = 17;
    localparam int SCALE_W  = 23;
    localparam int PAD_W    = 12;
    localparam int SIZE_W   = 14;
    localparam int COUNT_W  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SCALE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_X           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_Y           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DETECTIONS  = 3'd6;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd16384;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 23'd65536;
    localparam logic [PAD_W-1:0]    PAD_RESET    = 12'd0;
    localparam logic [SIZE_W-1:0]   SIZE_RESET   = 14'd640;
    localparam logic [COUNT_W-1:0]  MAXDET_RESET = 16'd300;

    localparam logic signed [VALUE_W-1:0] MINUS_ONE_Q16 = -32'sd65536;

    localparam logic KIND_BOX   = 1'b0;
    localparam logic KIND_COEFF = 1'b1;

    typedef struct packed {
        logic [THRESH_W-1:0] keep_level;
        logic [SCALE_W-1:0]  inverse_scale;
        logic [PAD_W-1:0]    pad_x;
        logic [PAD_W-1:0]    pad_y;
        logic [SIZE_W-1:0]   image_width;
        logic [SIZE_W-1:0]   image_height;
        logic [COUNT_W-1:0]  max_detections;
    } dhbd_cfg_t;

    typedef struct packed {
        logic                       kind;
        logic signed [SUM_W-1:0]    sum_left;
        logic signed [SUM_W-1:0]    sum_top;
        logic signed [SUM_W-1:0]    sum_right;
        logic signed [SUM_W-1:0]    sum_bottom;
        logic signed [VALUE_W-1:0]  best_score;
        logic [CLASS_W-1:0]         class_index;
        logic signed [VALUE_W-1:0]  coefficient;
        logic                       last_of_anchor;
    } dhbd_req_t;

    typedef struct packed {
        logic                       kind;
        logic signed [PROD_W-1:0]   prod_left;
        logic signed [PROD_W-1:0]   prod_top;
        logic signed [PROD_W-1:0]   prod_right;
        logic signed [PROD_W-1:0]   prod_bottom;
        logic signed [VALUE_W-1:0]  best_score;
        logic [CLASS_W-1:0]         class_index;
        logic signed [VALUE_W-1:0]  coefficient;
        logic                       last_of_anchor;
    } dhbd_prod_t;

endpackage

`default_nettype wire

### src/dhbd_if.sv
// Stream interfaces for head values in and decoded results out
`default_nettype none

interface dhbd_head_if import dhbd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] channel_value;
    logic                      frame_end;

    modport source (output valid, output channel_value, output frame_end, input ready);
    modport sink   (input valid, input channel_value, input frame_end, output ready);
endinterface

interface dhbd_result_if import dhbd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [CORNER_W-1:0]       left;
    logic [CORNER_W-1:0]       top;
    logic [CORNER_W-1:0]       right;
    logic [CORNER_W-1:0]       bottom;
    logic signed [VALUE_W-1:0] best_score;
    logic [CLASS_W-1:0]        class_index;
    logic signed [VALUE_W-1:0] coefficient;
    logic                      last_of_anchor;

    modport source (
        output valid, output kind, output left, output top, output right, output bottom,
        output best_score, output class_index, output coefficient, output last_of_anchor,
        input ready
    );
    modport sink (
        input valid, input kind, input left, input top, input right, input bottom,
        input best_score, input class_index, input coefficient, input last_of_anchor,
        output ready
    );
endinterface

`default_nettype wire

### src/dhbd_cfg.sv
// Configuration register file
`default_nettype none

module dhbd_cfg import dhbd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output dhbd_cfg_t             cfg
);

    dhbd_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keep_level      <= THRESH_RESET;
            cfg_reg.inverse_scale   <= SCALE_RESET;
            cfg_reg.pad_x           <= PAD_RESET;
            cfg_reg.pad_y           <= PAD_RESET;
            cfg_reg.image_width     <= SIZE_RESET;
            cfg_reg.image_height    <= SIZE_RESET;
            cfg_reg.max_detections  <= MAXDET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEEP_LEVEL:      cfg_reg.keep_level      <= cfg_data[THRESH_W-1:0];
                CFG_INVERSE_SCALE:   cfg_reg.inverse_scale   <= cfg_data[SCALE_W-1:0];
                CFG_PAD_X:           cfg_reg.pad_x           <= cfg_data[PAD_W-1:0];
                CFG_PAD_Y:           cfg_reg.pad_y           <= cfg_data[PAD_W-1:0];
                CFG_IMAGE_WIDTH:     cfg_reg.image_width     <= cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:    cfg_reg.image_height    <= cfg_data[SIZE_W-1:0];
                CFG_MAX_DETECTIONS:  cfg_reg.max_detections  <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### src/dhbd_tracker.sv
// Channel position tracking, best class search and keep decision
`default_nettype none

module dhbd_tracker import dhbd_pkg::*; #(
    parameter int CLASS_COUNT = CLASS_COUNT_DEF,
    parameter int NUM_COEFFS  = NUM_COEFFS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dhbd_head_if.sink  head,
    input  dhbd_cfg_t  cfg,
    output logic       req_valid,
    output dhbd_req_t  req,
    input  logic       req_ready
);

    localparam int TOTAL_CH       = 4 + CLASS_COUNT + NUM_COEFFS;
    localparam int POS_W          = $clog2(TOTAL_CH);
    localparam int LAST_CLASS_POS = 3 + CLASS_COUNT;
    localparam int LAST_POS       = TOTAL_CH - 1;

    typedef logic [POS_W-1:0] pos_t;

    pos_t                      pos_reg;
    logic signed [VALUE_W-1:0] best_score_reg;
    logic [CLASS_W-1:0]        best_class_reg;
    logic                      anchor_kept_reg;
    logic [COUNT_W-1:0]        kept_count_reg;

    logic signed [VALUE_W-1:0] cx_reg;
    logic signed [VALUE_W-1:0] cy_reg;
    logic signed [SUM_W-1:0]   sum_left_reg;
    logic signed [SUM_W-1:0]   sum_right_reg;
    logic signed [SUM_W-1:0]   sum_top_reg;
    logic signed [SUM_W-1:0]   sum_bottom_reg;

    logic      req_valid_reg;
    dhbd_req_t req_reg;
    dhbd_req_t req_next;

    logic                      accept;
    logic signed [VALUE_W-1:0] value;
    logic signed [SUM_W-1:0]   value_ext;
    logic signed [SUM_W-1:0]   twice_cx;
    logic signed [SUM_W-1:0]   twice_cy;
    logic                      in_box;
    logic                      in_class;
    logic                      last_class;
    logic                      last_pos;
    logic                      better;
    logic signed [VALUE_W-1:0] best_next;
    logic [31:0]               class_off;
    logic [CLASS_W-1:0]        class_next;
    logic                      keep;
    logic                      emit_box;
    logic                      emit_coeff;
    logic                      emit;

    assign head.ready = !req_valid_reg || req_ready;
    assign accept     = head.valid && head.ready;
    assign value      = head.channel_value;
    assign value_ext  = {{(SUM_W-VALUE_W){value[VALUE_W-1]}}, value};
    assign twice_cx   = {cx_reg[VALUE_W-1], cx_reg, 1'b0};
    assign twice_cy   = {cy_reg[VALUE_W-1], cy_reg, 1'b0};

    assign in_box     = pos_reg < POS_W'(4);
    assign in_class   = !in_box && (pos_reg <= POS_W'(LAST_CLASS_POS));
    assign last_class = pos_reg == POS_W'(LAST_CLASS_POS);
    assign last_pos   = pos_reg == POS_W'(LAST_POS);

    assign better     = value > best_score_reg;
    assign best_next  = better ? value : best_score_reg;
    assign class_off  = 32'(pos_reg) - 32'd4;
    assign class_next = better ? class_off[CLASS_W-1:0] : best_class_reg;
    assign keep       = (best_next >= $signed({15'd0, cfg.keep_level}))
                        && (kept_count_reg < cfg.max_detections);

    assign emit_box   = in_class && last_class && keep;
    assign emit_coeff = !in_box && !in_class && anchor_kept_reg;
    assign emit       = emit_box || emit_coeff;

    always_comb
    begin
        req_next = '0;
        if (emit_box)
        begin
            req_next.kind        = KIND_BOX;
            req_next.sum_left    = sum_left_reg;
            req_next.sum_top     = sum_top_reg;
            req_next.sum_right   = sum_right_reg;
            req_next.sum_bottom  = sum_bottom_reg;
            req_next.best_score  = best_next;
            req_next.class_index = class_next;
        end
        else if (emit_coeff)
        begin
            req_next.kind           = KIND_COEFF;
            req_next.coefficient    = value;
            req_next.last_of_anchor = last_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            best_score_reg  <= MINUS_ONE_Q16;
            best_class_reg  <= '0;
            anchor_kept_reg <= 1'b0;
            kept_count_reg  <= '0;
            req_valid_reg   <= 1'b0;
        end
        else
        begin
            if (head.ready)
            begin
                req_valid_reg <= accept && emit;
            end
            if (accept)
            begin
                if (last_pos || head.frame_end)
                begin
                    pos_reg         <= '0;
                    best_score_reg  <= MINUS_ONE_Q16;
                    best_class_reg  <= '0;
                    anchor_kept_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                    if (in_class)
                    begin
                        best_score_reg <= best_next;
                        best_class_reg <= class_next;
                        if (last_class)
                        begin
                            anchor_kept_reg <= keep;
                        end
                    end
                end
                if (head.frame_end)
                begin
                    kept_count_reg <= '0;
                end
                else if (emit_box)
                begin
                    kept_count_reg <= kept_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (head.ready && accept && emit)
        begin
            req_reg <= req_next;
        end
        if (accept && in_box)
        begin
            case (pos_reg)
                POS_W'(0): cx_reg <= value;
                POS_W'(1): cy_reg <= value;
                POS_W'(2):
                begin
                    sum_left_reg  <= twice_cx - value_ext;
                    sum_right_reg <= twice_cx + value_ext;
                end
                POS_W'(3):
                begin
                    sum_top_reg    <= twice_cy - value_ext;
                    sum_bottom_reg <= twice_cy + value_ext;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign req_valid = req_valid_reg;
    assign req       = req_reg;

    assert property (@(posedge clk) disable iff (!rst_n) int'(pos_reg) <= LAST_POS)
        else $error("channel position past the end of the anchor");

    assert property (@(posedge clk) disable iff (!rst_n)
        int'(best_class_reg) < CLASS_COUNT)
        else $error("best class out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !emit) |=> !req_valid_reg)
        else $error("request raised for an item that yields no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !req_ready) |=> (req_valid_reg && $stable(req_reg)))
        else $error("stalled request lost or changed");

endmodule

`default_nettype wire

### src/dhbd_scale.sv
// Unpad and scale stage: one multiply per corner, registered
`default_nettype none

module dhbd_scale import dhbd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  dhbd_cfg_t  cfg,
    input  logic       req_valid,
    input  dhbd_req_t  req,
    output logic       req_ready,
    output logic       prod_valid,
    output dhbd_prod_t prod,
    input  logic       prod_ready
);

    function automatic logic signed [PROD_W-1:0] scale_corner(
        input logic signed [SUM_W-1:0] sum,
        input logic [PAD_W-1:0]        pad,
        input logic [SCALE_W-1:0]      inv
    );
        logic signed [SUM_W:0]     d;
        logic signed [SCALE_W:0]   inv_s;
        d     = {sum[SUM_W-1], sum} - $signed({{(SUM_W-PAD_W-17){1'b0}}, pad, 17'd0});
        inv_s = $signed({1'b0, inv});
        return d * inv_s;
    endfunction

    logic       prod_valid_reg;
    dhbd_prod_t prod_reg;
    dhbd_prod_t prod_next;

    assign req_ready = !prod_valid_reg || prod_ready;

    always_comb
    begin
        prod_next.kind           = req.kind;
        prod_next.prod_left      = scale_corner(req.sum_left, cfg.pad_x, cfg.inverse_scale);
        prod_next.prod_right     = scale_corner(req.sum_right, cfg.pad_x, cfg.inverse_scale);
        prod_next.prod_top       = scale_corner(req.sum_top, cfg.pad_y, cfg.inverse_scale);
        prod_next.prod_bottom    = scale_corner(req.sum_bottom, cfg.pad_y, cfg.inverse_scale);
        prod_next.best_score     = req.best_score;
        prod_next.class_index    = req.class_index;
        prod_next.coefficient    = req.coefficient;
        prod_next.last_of_anchor = req.last_of_anchor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            prod_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

`default_nettype wire

### src/dhbd_clamp.sv
// Clamp stage and result register
`default_nettype none

module dhbd_clamp import dhbd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  dhbd_cfg_t    cfg,
    input  logic         prod_valid,
    input  dhbd_prod_t   prod,
    output logic         prod_ready,
    dhbd_result_if.source result
);

    typedef struct packed {
        logic                      kind;
        logic [CORNER_W-1:0]       left;
        logic [CORNER_W-1:0]       top;
        logic [CORNER_W-1:0]       right;
        logic [CORNER_W-1:0]       bottom;
        logic signed [VALUE_W-1:0] best_score;
        logic [CLASS_W-1:0]        class_index;
        logic signed [VALUE_W-1:0] coefficient;
        logic                      last_of_anchor;
    } out_t;

    function automatic logic [CORNER_W-1:0] clamp_corner(
        input logic signed [PROD_W-1:0] p,
        input logic [SIZE_W-1:0]        size
    );
        logic [SIZE_W-2:0]       span;
        logic [CORNER_W-1:0]     limit;
        logic [PROD_W-18:0]      q;
        logic [CORNER_W-1:0]     r;
        if (size == '0)
            span = '0;
        else if (size > 14'd8192)
            span = '1;
        else
            span = 13'(size - 1'b1);
        limit = {span, 16'd0};
        q     = p[PROD_W-1:17];
        if (p <= 0)
            r = '0;
        else if (q > {{(PROD_W-17-CORNER_W){1'b0}}, limit})
            r = limit;
        else
            r = q[CORNER_W-1:0];
        return r;
    endfunction

    logic out_valid_reg;
    out_t out_reg;
    out_t out_next;

    assign prod_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        out_next.kind           = prod.kind;
        out_next.left           = clamp_corner(prod.prod_left, cfg.image_width);
        out_next.right          = clamp_corner(prod.prod_right, cfg.image_width);
        out_next.top            = clamp_corner(prod.prod_top, cfg.image_height);
        out_next.bottom         = clamp_corner(prod.prod_bottom, cfg.image_height);
        out_next.best_score     = prod.best_score;
        out_next.class_index    = prod.class_index;
        out_next.coefficient    = prod.coefficient;
        out_next.last_of_anchor = prod.last_of_anchor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (prod_ready)
        begin
            out_valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && prod_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = out_reg.kind;
    assign result.left           = out_reg.left;
    assign result.top            = out_reg.top;
    assign result.right          = out_reg.right;
    assign result.bottom         = out_reg.bottom;
    assign result.best_score     = out_reg.best_score;
    assign result.class_index    = out_reg.class_index;
    assign result.coefficient    = out_reg.coefficient;
    assign result.last_of_anchor = out_reg.last_of_anchor;

endmodule

`default_nettype wire

### src/detection_head_box_decode.sv
// A result passes the tracker request, scale product and clamp result registers in turn.
// Throughput: one head value per cycle unless stalled; each of these stages holds one request.
// A box result comes from the last class score of a kept anchor, coefficients follow one each.
// Reset clears the channel position, running best (-1.0), kept flag, box count and stage
// valids, and returns every configuration register to its default.
`default_nettype none

module detection_head_box_decode import dhbd_pkg::*; #(
    parameter int CLASS_COUNT = CLASS_COUNT_DEF,
    parameter int NUM_COEFFS  = NUM_COEFFS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dhbd_head_if.sink             head,
    dhbd_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dhbd_cfg_t  cfg;
    logic       req_valid;
    logic       req_ready;
    dhbd_req_t  req;
    logic       prod_valid;
    logic       prod_ready;
    dhbd_prod_t prod;

    dhbd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dhbd_tracker #(
        .CLASS_COUNT (CLASS_COUNT),
        .NUM_COEFFS  (NUM_COEFFS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready)
    );

    dhbd_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req_valid  (req_valid),
        .req        (req),
        .req_ready  (req_ready),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_ready (prod_ready)
    );

    dhbd_clamp u_clamp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_ready (prod_ready),
        .result     (result)
    );

endmodule

`default_nettype wire
